@@ hw/rtl/edcv_pkg.sv @@
// ----------------------------------------------------------------------------
// Echo distance smoothing package
// Shared types and constants for the smoothed echo distance to DAC code unit.
// ----------------------------------------------------------------------------
`default_nettype none

package edcv_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FILT,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } state_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_ALPHA    = 2'd0;
  localparam logic [1:0] REG_DIST_MIN = 2'd1;
  localparam logic [1:0] REG_DIST_MAX = 2'd2;

  // Register values after reset.
  localparam logic [15:0] ALPHA_RESET    = 16'd6554;
  localparam logic [17:0] DIST_MIN_RESET = 18'd1024;
  localparam logic [17:0] DIST_MAX_RESET = 18'd17920;

  // 0.01715 cm/us in Q10.8 with 16 extra fraction bits.
  localparam logic [18:0] DIST_SCALE = 19'd287729;
  // Number of DAC steps between the clamp limits.
  localparam logic [11:0] DAC_SPAN   = 12'd4094;

  // Last step index of each serial phase.
  localparam logic [3:0] MUL_LAST  = 4'd14;
  localparam logic [3:0] FILT_LAST = 4'd15;
  localparam logic [3:0] DIV_LAST  = 4'd11;

endpackage

`default_nettype wire

@@ hw/rtl/echo_distance_smoothed_cv_unit.sv @@
// An input transaction passes through the distance multiply when the echo duration
// is nonzero, the filter update once the filter is loaded, a prepare step, and the
// code division when an echo has been seen and the clamp range is not empty.
// The next item is taken once the
// result sits in the output register. Synchronous reset restores the register
// defaults and clears the filter; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Smoothed echo distance to DAC code
// Converts an echo duration to a distance, runs it through an exponential
// average and maps the clamped result onto a 12-bit DAC code, with
// one-bit-per-cycle shift-and-add and restoring-division units and a combinational span multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module echo_distance_smoothed_cv_unit
  import edcv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [17:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [14:0] echo_duration_us,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      dac_code,
  output logic [17:0]      filtered_distance,
  output logic             distance_valid
);

  state_t state;
  state_t state_next;

  logic [15:0] alpha;
  logic [17:0] dist_min;
  logic [17:0] dist_max;
  logic [17:0] smoothed;
  logic        have;

  logic [3:0]         cnt;
  logic [14:0]        us_sh;
  logic [33:0]        acc;
  logic [15:0]        a_sh;
  logic signed [18:0] diff;
  logic signed [35:0] prod;
  logic [17:0]        rem;
  logic [11:0]        num_lo;
  logic [17:0]        den;
  logic [11:0]        quo;
  logic [11:0]        res_code;

  logic               in_take;
  logic               out_free;
  logic [33:0]        acc_next;
  logic [17:0]        dist_w;
  logic signed [35:0] prod_next;
  logic [35:0]        filt_sum;
  logic [17:0]        d_clamp;
  logic [17:0]        offset;
  logic [29:0]        num;
  logic [18:0]        r_sh;
  logic               r_ge;
  logic [17:0]        rem_next;
  logic [11:0]        quo_next;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha    <= ALPHA_RESET;
      dist_min <= DIST_MIN_RESET;
      dist_max <= DIST_MAX_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ALPHA:    alpha    <= cfg_data[15:0];
        REG_DIST_MIN: dist_min <= cfg_data;
        REG_DIST_MAX: dist_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // Serial arithmetic steps.
  always_comb begin
    acc_next  = {acc[32:0], 1'b0} + (us_sh[14] ? {15'd0, DIST_SCALE} : 34'd0);
    dist_w    = acc_next[33:16];
    prod_next = {prod[34:0], 1'b0} + (a_sh[15] ? {{17{diff[18]}}, diff} : 36'sd0);
    // The true sum is never negative, so its bits above 16 are the floor.
    filt_sum  = {2'b00, smoothed, 16'd0} + prod_next;
    if (smoothed < dist_min) begin
      d_clamp = dist_min;
    end else if (smoothed > dist_max) begin
      d_clamp = dist_max;
    end else begin
      d_clamp = smoothed;
    end
    offset   = d_clamp - dist_min;
    num      = {12'd0, offset} * {18'd0, DAC_SPAN};
    r_sh     = {rem, num_lo[11]};
    r_ge     = (r_sh >= {1'b0, den});
    rem_next = r_ge ? 18'(r_sh - {1'b0, den}) : r_sh[17:0];
    quo_next = {quo[10:0], r_ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          state_next = (echo_duration_us != 15'd0) ? ST_MUL : ST_PREP;
        end
      end
      ST_MUL: begin
        if (cnt == MUL_LAST) begin
          state_next = have ? ST_FILT : ST_PREP;
        end
      end
      ST_FILT: begin
        if (cnt == FILT_LAST) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = (have && (dist_max > dist_min)) ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        if (cnt == DIV_LAST) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed <= 18'd0;
      have     <= 1'b0;
    end else if (state == ST_MUL && cnt == MUL_LAST && !have) begin
      smoothed <= dist_w;
      have     <= 1'b1;
    end else if (state == ST_FILT && cnt == FILT_LAST) begin
      smoothed <= filt_sum[33:16];
    end
  end

  // Datapath shift registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        us_sh <= echo_duration_us;
        acc   <= 34'd0;
        cnt   <= 4'd0;
      end
      ST_MUL: begin
        us_sh <= {us_sh[13:0], 1'b0};
        acc   <= acc_next;
        if (cnt == MUL_LAST) begin
          diff <= $signed({1'b0, dist_w}) - $signed({1'b0, smoothed});
          a_sh <= alpha;
          prod <= 36'sd0;
          cnt  <= 4'd0;
        end else begin
          cnt  <= cnt + 4'd1;
        end
      end
      ST_FILT: begin
        a_sh <= {a_sh[14:0], 1'b0};
        prod <= prod_next;
        cnt  <= cnt + 4'd1;
      end
      ST_PREP: begin
        // The quotient stays below 4096, so the top bits start below den.
        rem      <= num[29:12];
        num_lo   <= num[11:0];
        den      <= dist_max - dist_min;
        quo      <= 12'd0;
        cnt      <= 4'd0;
        res_code <= have ? 12'd1 : 12'd0;
      end
      ST_DIV: begin
        rem    <= rem_next;
        num_lo <= {num_lo[10:0], 1'b0};
        quo    <= quo_next;
        cnt    <= cnt + 4'd1;
        if (cnt == DIV_LAST) begin
          res_code <= quo_next + 12'd1;
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      dac_code          <= res_code;
      filtered_distance <= smoothed;
      distance_valid    <= have;
    end
  end

`ifndef SYNTHESIS
  a_empty_filter_zero: assert property (@(posedge clk) disable iff (rst)
    !have |-> smoothed == 18'd0)
    else $error("filter holds a distance before any echo");

  a_code_zero_without_echo: assert property (@(posedge clk) disable iff (rst)
    out_valid && !distance_valid |-> dac_code == 12'd0)
    else $error("nonzero code before any echo");

  a_code_nonzero_with_echo: assert property (@(posedge clk) disable iff (rst)
    out_valid && distance_valid |-> dac_code != 12'd0)
    else $error("zero code after an echo");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> den != 18'd0)
    else $error("division started with an empty clamp range");
`endif

endmodule

`default_nettype wire
